@@ rtl/dpnd_pkg.sv @@
// ----------------------------------------------------------------------------
// dpnd_pkg
// Shared types and constants of the dictionary prefix nibble decoder.
// ----------------------------------------------------------------------------
package dpnd_pkg;

  localparam int MAX_TOKEN_BYTES = 6;
  localparam int BYTES_W         = 48;
  localparam int SYM_BYTES_W     = 32;
  localparam int LEN_W           = 3;
  localparam int TOK_ENTRY_W     = LEN_W + BYTES_W;
  localparam int SYM_ENTRY_W     = LEN_W + SYM_BYTES_W;
  localparam int TOK_DEPTH       = 256;
  localparam int L1_DEPTH        = 32;
  localparam int L2_DEPTH        = 256;

  localparam logic [LEN_W-1:0] TOK_LEN_MAX =
    LEN_W'((MAX_TOKEN_BYTES < 6) ? MAX_TOKEN_BYTES : 6);
  localparam logic [LEN_W-1:0] SYM_LEN_MAX = LEN_W'(4);

  localparam logic [1:0] CMD_DECODE  = 2'd0;
  localparam logic [1:0] CMD_LOAD_TK = 2'd1;
  localparam logic [1:0] CMD_LOAD_L1 = 2'd2;
  localparam logic [1:0] CMD_LOAD_L2 = 2'd3;

  localparam logic [3:0] NEED_L1  = 4'd5;
  localparam logic [3:0] NEED_LEN = 4'd3;
  localparam logic [3:0] NEED_STD = 4'd8;

  typedef enum logic [2:0] {
    PH_PREFIX  = 3'd0,
    PH_ONE     = 3'd1,
    PH_ONE_ONE = 3'd2,
    PH_TOKEN   = 3'd3,
    PH_LEVEL1  = 3'd4,
    PH_LEVEL2  = 3'd5,
    PH_RAWLEN  = 3'd6,
    PH_RAWBYTE = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    EV_TOKEN  = 2'd0,
    EV_LEVEL1 = 2'd1,
    EV_LEVEL2 = 2'd2,
    EV_RAW    = 2'd3
  } ev_kind_t;

  typedef struct packed {
    logic       valid;
    ev_kind_t   kind;
    logic [7:0] data;
  } parse_event_t;

  typedef struct packed {
    logic               valid;
    logic [LEN_W-1:0]   len;
    logic [BYTES_W-1:0] bytes;
  } emit_load_t;

endpackage

@@ rtl/dpnd_if.sv @@
// ----------------------------------------------------------------------------
// dpnd_if
// Valid/ready channels of the decoder: input transactions and text bytes.
// ----------------------------------------------------------------------------
interface dpnd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [3:0]  code_nibble;
  logic        message_end;
  logic [7:0]  entry_index;
  logic [2:0]  entry_length;
  logic [47:0] entry_bytes;

  modport source (
    output valid, command, code_nibble, message_end, entry_index,
           entry_length, entry_bytes,
    input  ready
  );
  modport sink (
    input  valid, command, code_nibble, message_end, entry_index,
           entry_length, entry_bytes,
    output ready
  );
endinterface

interface dpnd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       run_last;

  modport source (output valid, text_byte, run_last, input ready);
  modport sink (input valid, text_byte, run_last, output ready);
endinterface

@@ rtl/dpnd_ram.sv @@
// ----------------------------------------------------------------------------
// dpnd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dpnd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/dpnd_parser.sv @@
// ----------------------------------------------------------------------------
// dpnd_parser
// Prefix code parser: consumes one nibble per step, reports a completed code.
// ----------------------------------------------------------------------------
module dpnd_parser
  import dpnd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step_en,
  input  logic [3:0]   nibble,
  input  logic         msg_end,
  output parse_event_t event_o
);

  phase_t     phase_r,  phase_nxt;
  logic [7:0] gather_r, gather_nxt;
  logic [3:0] count_r,  count_nxt;
  logic [2:0] left_r,   left_nxt;

  phase_t     ph_s  [5];
  logic [7:0] g_s   [5];
  logic [3:0] n_s   [5];
  logic [2:0] r_s   [5];

  // next state: walk the four bits
  always_comb begin
    logic       b;
    logic [7:0] g2;
    logic [3:0] n2;
    logic [3:0] need;
    logic [2:0] r2;
    ph_s[0] = phase_r;
    g_s[0]  = gather_r;
    n_s[0]  = count_r;
    r_s[0]  = left_r;
    for (int i = 0; i < 4; i++) begin
      b  = nibble[3-i];
      g2 = {g_s[i][6:0], b};
      n2 = n_s[i] + 4'd1;
      r2 = r_s[i] - 3'd1;
      ph_s[i+1] = ph_s[i];
      g_s[i+1]  = g_s[i];
      n_s[i+1]  = n_s[i];
      r_s[i+1]  = r_s[i];
      need = (ph_s[i] == PH_LEVEL1) ? NEED_L1 :
             (ph_s[i] == PH_RAWLEN) ? NEED_LEN : NEED_STD;
      case (ph_s[i])
        PH_PREFIX: begin
          ph_s[i+1] = b ? PH_ONE : PH_TOKEN;
          g_s[i+1]  = 8'd0;
          n_s[i+1]  = 4'd0;
        end
        PH_ONE: begin
          ph_s[i+1] = b ? PH_ONE_ONE : PH_LEVEL1;
        end
        PH_ONE_ONE: begin
          ph_s[i+1] = b ? PH_RAWLEN : PH_LEVEL2;
        end
        default: begin
          if (n2 < need) begin
            g_s[i+1] = g2;
            n_s[i+1] = n2;
          end else begin
            g_s[i+1] = 8'd0;
            n_s[i+1] = 4'd0;
            case (ph_s[i])
              PH_RAWLEN: begin
                r_s[i+1]  = g2[2:0];
                ph_s[i+1] = (g2[2:0] != 3'd0) ? PH_RAWBYTE : PH_PREFIX;
              end
              PH_RAWBYTE: begin
                r_s[i+1]  = r2;
                ph_s[i+1] = (r2 == 3'd0) ? PH_PREFIX : PH_RAWBYTE;
              end
              default: begin
                ph_s[i+1] = PH_PREFIX;
              end
            endcase
          end
        end
      endcase
    end
    if (msg_end) begin
      phase_nxt  = PH_PREFIX;
      gather_nxt = 8'd0;
      count_nxt  = 4'd0;
      left_nxt   = 3'd0;
    end else begin
      phase_nxt  = ph_s[4];
      gather_nxt = g_s[4];
      count_nxt  = n_s[4];
      left_nxt   = r_s[4];
    end
  end

  // outputs: report the code that completes inside this nibble
  always_comb begin
    logic [7:0] g2;
    logic [3:0] n2;
    logic [3:0] need;
    event_o = '{valid: 1'b0, kind: EV_RAW, data: 8'd0};
    for (int i = 0; i < 4; i++) begin
      g2   = {g_s[i][6:0], nibble[3-i]};
      n2   = n_s[i] + 4'd1;
      need = (ph_s[i] == PH_LEVEL1) ? NEED_L1 :
             (ph_s[i] == PH_RAWLEN) ? NEED_LEN : NEED_STD;
      if (n2 >= need) begin
        case (ph_s[i])
          PH_TOKEN:   event_o = '{valid: 1'b1, kind: EV_TOKEN,  data: g2};
          PH_LEVEL1:  event_o = '{valid: 1'b1, kind: EV_LEVEL1, data: g2};
          PH_LEVEL2:  event_o = '{valid: 1'b1, kind: EV_LEVEL2, data: g2};
          PH_RAWBYTE: event_o = '{valid: 1'b1, kind: EV_RAW,    data: g2};
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PREFIX;
      gather_r <= 8'd0;
      count_r  <= 4'd0;
      left_r   <= 3'd0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      gather_r <= gather_nxt;
      count_r  <= count_nxt;
      left_r   <= left_nxt;
    end
  end

endmodule

@@ rtl/dpnd_emit.sv @@
// ----------------------------------------------------------------------------
// dpnd_emit
// Output serializer: shifts out one entry's bytes, one transaction per byte.
// ----------------------------------------------------------------------------
module dpnd_emit
  import dpnd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  emit_load_t load,
  output logic       load_ready,
  dpnd_out_if.source out_ch
);

  logic [LEN_W-1:0]   left_r,  left_nxt;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;
  logic               fire;

  assign fire       = out_ch.valid && out_ch.ready;
  assign load_ready = (left_r == '0) || (left_r == LEN_W'(1) && out_ch.ready);

  always_comb begin
    left_nxt  = left_r;
    bytes_nxt = bytes_r;
    if (fire) begin
      left_nxt  = left_r - LEN_W'(1);
      bytes_nxt = {bytes_r[BYTES_W-9:0], 8'd0};
    end
    if (load.valid && load_ready) begin
      left_nxt  = load.len;
      bytes_nxt = load.bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

  assign out_ch.valid     = (left_r != '0);
  assign out_ch.text_byte = bytes_r[BYTES_W-1 -: 8];
  assign out_ch.run_last  = (left_r == LEN_W'(1));

endmodule

@@ rtl/dictionary_prefix_nibble_decoder.sv @@
// ----------------------------------------------------------------------------
// dictionary_prefix_nibble_decoder
// Prefix code nibble decoder with dictionary and two symbol tables.
// ----------------------------------------------------------------------------
// A transaction is accepted in any cycle in which the lookup stage is empty or
// hands its entry to the output serializer, so nibbles and load commands can
// arrive back to back. A decoded token or symbol code reads its table in the
// cycle of acceptance and the entry appears in the next cycle; the serializer
// then sends one text byte per cycle while the output is ready, so a nibble
// that completes an entry of N bytes yields N text bytes (up to 6 for a
// dictionary token). After reset a clearing pass writes every table entry
// empty, and no transaction is accepted until it ends; a load is visible to
// the next transaction.
// ----------------------------------------------------------------------------
module dictionary_prefix_nibble_decoder
  import dpnd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  dpnd_in_if.sink   in_ch,
  dpnd_out_if.source out_ch
);

  parse_event_t     ev;
  logic             acc, acc_dec;
  logic             tok_we, l1_we, l2_we;
  logic             tok_re, l1_re, l2_re;
  logic [LEN_W-1:0] tok_len, sym_len;

  logic                   tok_wen, l1_wen, l2_wen;
  logic [7:0]             wr_addr;
  logic [TOK_ENTRY_W-1:0] tok_wdata;
  logic [SYM_ENTRY_W-1:0] sym_wdata;

  logic [TOK_ENTRY_W-1:0] tok_rd;
  logic [SYM_ENTRY_W-1:0] l1_rd, l2_rd;

  logic       clr_active_r, clr_active_nxt;
  logic [7:0] clr_addr_r,   clr_addr_nxt;

  logic       p_valid_r, p_valid_nxt;
  ev_kind_t   p_kind_r;
  logic [7:0] p_raw_r;
  logic       p_adv;

  emit_load_t load;
  logic       load_ready;

  assign p_adv       = p_valid_r && load_ready;
  assign in_ch.ready = !clr_active_r && (!p_valid_r || load_ready);
  assign acc         = in_ch.valid && in_ch.ready;
  assign acc_dec     = acc && (in_ch.command == CMD_DECODE);

  assign tok_we = acc && (in_ch.command == CMD_LOAD_TK);
  assign l1_we  = acc && (in_ch.command == CMD_LOAD_L1) && (in_ch.entry_index[7:5] == 3'd0);
  assign l2_we  = acc && (in_ch.command == CMD_LOAD_L2);

  assign tok_len = (in_ch.entry_length > TOK_LEN_MAX) ? TOK_LEN_MAX : in_ch.entry_length;
  assign sym_len = (in_ch.entry_length > SYM_LEN_MAX) ? SYM_LEN_MAX : in_ch.entry_length;

  assign tok_re = acc_dec && ev.valid && (ev.kind == EV_TOKEN);
  assign l1_re  = acc_dec && ev.valid && (ev.kind == EV_LEVEL1);
  assign l2_re  = acc_dec && ev.valid && (ev.kind == EV_LEVEL2);

  // clearing pass: write every entry empty after reset
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + 8'd1;
      if (clr_addr_r == 8'(TOK_DEPTH - 1)) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= 8'd0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
    end
  end

  assign tok_wen   = clr_active_r || tok_we;
  assign l1_wen    = clr_active_r || l1_we;
  assign l2_wen    = clr_active_r || l2_we;
  assign wr_addr   = clr_active_r ? clr_addr_r : in_ch.entry_index;
  assign tok_wdata = clr_active_r ? '0 : {tok_len, in_ch.entry_bytes};
  assign sym_wdata = clr_active_r ? '0 : {sym_len, in_ch.entry_bytes[47:16]};

  dpnd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (acc_dec),
    .nibble  (in_ch.code_nibble),
    .msg_end (in_ch.message_end),
    .event_o (ev)
  );

  dpnd_ram #(.WIDTH(TOK_ENTRY_W), .DEPTH(TOK_DEPTH)) u_tok_ram (
    .clk   (clk),
    .we    (tok_wen),
    .waddr (wr_addr),
    .wdata (tok_wdata),
    .re    (tok_re),
    .raddr (ev.data),
    .rdata (tok_rd)
  );

  dpnd_ram #(.WIDTH(SYM_ENTRY_W), .DEPTH(L1_DEPTH)) u_l1_ram (
    .clk   (clk),
    .we    (l1_wen),
    .waddr (wr_addr[4:0]),
    .wdata (sym_wdata),
    .re    (l1_re),
    .raddr (ev.data[4:0]),
    .rdata (l1_rd)
  );

  dpnd_ram #(.WIDTH(SYM_ENTRY_W), .DEPTH(L2_DEPTH)) u_l2_ram (
    .clk   (clk),
    .we    (l2_wen),
    .waddr (wr_addr),
    .wdata (sym_wdata),
    .re    (l2_re),
    .raddr (ev.data),
    .rdata (l2_rd)
  );

  // lookup stage
  always_comb begin
    p_valid_nxt = p_valid_r;
    if (p_adv) begin
      p_valid_nxt = 1'b0;
    end
    if (acc_dec && ev.valid) begin
      p_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= p_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_dec && ev.valid) begin
      p_kind_r <= ev.kind;
      p_raw_r  <= ev.data;
    end
  end

  always_comb begin
    load.valid = p_valid_r;
    case (p_kind_r)
      EV_TOKEN: begin
        load.len   = tok_rd[TOK_ENTRY_W-1 -: LEN_W];
        load.bytes = tok_rd[BYTES_W-1:0];
      end
      EV_LEVEL1: begin
        load.len   = l1_rd[SYM_ENTRY_W-1 -: LEN_W];
        load.bytes = {l1_rd[SYM_BYTES_W-1:0], 16'd0};
      end
      EV_LEVEL2: begin
        load.len   = l2_rd[SYM_ENTRY_W-1 -: LEN_W];
        load.bytes = {l2_rd[SYM_BYTES_W-1:0], 16'd0};
      end
      EV_RAW: begin
        load.len   = LEN_W'(1);
        load.bytes = {p_raw_r, 40'd0};
      end
      default: begin
        load.len   = '0;
        load.bytes = '0;
      end
    endcase
  end

  dpnd_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .load_ready (load_ready),
    .out_ch     (out_ch)
  );

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dictionary prefix nibble decoder.
// A directed table loads the three tables and walks every code kind, then
// random messages of well-formed codes, broken codes, noise nibbles and
// interleaved loads run with random idling on both channels. Each text byte
// is checked in order against the directed rows or an in-bench parser predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import dpnd_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 175;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  nibble;
    logic        last;
    logic [7:0]  index;
    logic [2:0]  length;
    logic [47:0] bytes;
    logic        typed;
    logic [2:0]  exp_count;
    logic [47:0] exp_bytes;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } text_rec_t;

  localparam stim_row_t DIRECTED_ROWS [25] = '{
    '{CMD_LOAD_TK, 4'hF, 1'b1, 8'hFF, 3'd7, 48'hFFEEDDCCBBAA, 1'b1, 3'd0, 48'h0},
    '{CMD_LOAD_L1, 4'h0, 1'b0, 8'h1F, 3'd5, 48'hF09F98800000, 1'b1, 3'd0, 48'h0},
    '{CMD_LOAD_L1, 4'h0, 1'b0, 8'h20, 3'd1, 48'h410000000000, 1'b1, 3'd0, 48'h0},
    '{CMD_LOAD_L2, 4'h0, 1'b0, 8'h00, 3'd7, 48'hE282AC41FFFF, 1'b1, 3'd0, 48'h0},
    '{CMD_LOAD_TK, 4'h0, 1'b0, 8'h00, 3'd0, 48'hFFFFFFFFFFFF, 1'b1, 3'd0, 48'h0},
    '{CMD_DECODE, 4'b0111, 1'b0, 8'h00, 3'd0, 48'h0, 1'b0, 3'd0, 48'h0},
    '{CMD_DECODE, 4'b1111, 1'b0, 8'h00, 3'd0, 48'h0, 1'b0, 3'd0, 48'h0},
    '{CMD_DECODE, 4'b1000, 1'b1, 8'h00, 3'd0, 48'h0, 1'b1, 3'd6, 48'hFFEEDDCCBBAA},
    '{CMD_DECODE, 4'b1011, 1'b0, 8'h00, 3'd0, 48'h0, 1'b0, 3'd0, 48'h0},
    '{CMD_DECODE, 4'b1110, 1'b1, 8'h00, 3'd0, 48'h0, 1'b1, 3'd4, 48'hF09F98800000},
    '{CMD_DECODE, 4'b1000, 1'b0, 8'h00, 3'd0, 48'h0, 1'b0, 3'd0, 48'h0},
    '{CMD_DECODE, 4'b0001, 1'b1, 8'h00, 3'd0, 48'h0, 1'b1, 3'd0, 48'h0},
    '{CMD_DECODE, 4'b1100, 1'b0, 8'h00, 3'd0, 48'h0, 1'b0, 3'd0, 48'h0},
    '{CMD_DECODE, 4'b0000, 1'b0, 8'h00, 3'd0, 48'h0, 1'b0, 3'd0, 48'h0},
    '{CMD_DECODE, 4'b0000, 1'b1, 8'h00, 3'd0, 48'h0, 1'b1, 3'd4, 48'hE282AC410000},
    '{CMD_DECODE, 4'b1110, 1'b0, 8'h00, 3'd0, 48'h0, 1'b0, 3'd0, 48'h0},
    '{CMD_DECODE, 4'b0011, 1'b0, 8'h00, 3'd0, 48'h0, 1'b0, 3'd0, 48'h0},
    '{CMD_DECODE, 4'b1010, 1'b0, 8'h00, 3'd0, 48'h0, 1'b0, 3'd0, 48'h0},
    '{CMD_DECODE, 4'b0000, 1'b0, 8'h00, 3'd0, 48'h0, 1'b0, 3'd0, 48'h0},
    '{CMD_DECODE, 4'b0000, 1'b0, 8'h00, 3'd0, 48'h0, 1'b1, 3'd1, 48'h000000000000},
    '{CMD_DECODE, 4'b1111, 1'b0, 8'h00, 3'd0, 48'h0, 1'b0, 3'd0, 48'h0},
    '{CMD_DECODE, 4'b1111, 1'b1, 8'h00, 3'd0, 48'h0, 1'b1, 3'd1, 48'hFF0000000000},
    '{CMD_DECODE, 4'b0000, 1'b0, 8'h00, 3'd0, 48'h0, 1'b0, 3'd0, 48'h0},
    '{CMD_DECODE, 4'b0000, 1'b0, 8'h00, 3'd0, 48'h0, 1'b0, 3'd0, 48'h0},
    '{CMD_DECODE, 4'b0111, 1'b1, 8'h00, 3'd0, 48'h0, 1'b1, 3'd0, 48'h0}
  };

  logic clk;
  logic rst_n;

  dpnd_in_if  in_ch ();
  dpnd_out_if out_ch ();

  dictionary_prefix_nibble_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // predictor state
  logic [2:0]  token_len  [TOK_DEPTH];
  logic [47:0] token_text [TOK_DEPTH];
  logic [2:0]  sym1_len   [L1_DEPTH];
  logic [31:0] sym1_text  [L1_DEPTH];
  logic [2:0]  sym2_len   [L2_DEPTH];
  logic [31:0] sym2_text  [L2_DEPTH];
  phase_t      parse_ph;
  logic [7:0]  code_acc;
  logic [3:0]  code_cnt;
  logic [2:0]  raw_left;

  logic [47:0] emit_acc;
  int          emit_n;

  text_rec_t   text_expected [$];
  bit          code_bits [$];
  int          faults;
  int          stim_count;
  int          idle_cycles;
  bit          in_steady;

  function automatic void clear_parser();
    parse_ph = PH_PREFIX;
    code_acc = '0;
    code_cnt = '0;
    raw_left = '0;
  endfunction

  function automatic void clear_model();
    for (int i = 0; i < TOK_DEPTH; i++) begin
      token_len[i]  = '0;
      token_text[i] = '0;
      sym2_len[i]   = '0;
      sym2_text[i]  = '0;
    end
    for (int i = 0; i < L1_DEPTH; i++) begin
      sym1_len[i]  = '0;
      sym1_text[i] = '0;
    end
    clear_parser();
  endfunction

  function automatic void put_text(input logic [7:0] b);
    if (emit_n < 6) begin
      emit_acc[47 - 8 * emit_n -: 8] = b;
      emit_n++;
    end
  endfunction

  function automatic void take_code_bit(input logic b);
    logic [47:0] tok;
    logic [31:0] sym;
    logic [3:0]  need;
    case (parse_ph)
      PH_PREFIX: begin
        parse_ph = b ? PH_ONE : PH_TOKEN;
        code_acc = '0;
        code_cnt = '0;
      end
      PH_ONE: parse_ph = b ? PH_ONE_ONE : PH_LEVEL1;
      PH_ONE_ONE: parse_ph = b ? PH_RAWLEN : PH_LEVEL2;
      default: begin
        code_acc = {code_acc[6:0], b};
        code_cnt++;
        need = (parse_ph == PH_LEVEL1) ? NEED_L1 :
               (parse_ph == PH_RAWLEN) ? NEED_LEN : NEED_STD;
        if (code_cnt == need) begin
          code_cnt = '0;
          case (parse_ph)
            PH_TOKEN: begin
              tok = token_text[code_acc];
              for (int k = 0; k < int'(token_len[code_acc]); k++)
                put_text(tok[47 - 8 * k -: 8]);
              parse_ph = PH_PREFIX;
            end
            PH_LEVEL1: begin
              sym = sym1_text[code_acc[4:0]];
              for (int k = 0; k < int'(sym1_len[code_acc[4:0]]); k++)
                put_text(sym[31 - 8 * k -: 8]);
              parse_ph = PH_PREFIX;
            end
            PH_LEVEL2: begin
              sym = sym2_text[code_acc];
              for (int k = 0; k < int'(sym2_len[code_acc]); k++)
                put_text(sym[31 - 8 * k -: 8]);
              parse_ph = PH_PREFIX;
            end
            PH_RAWLEN: begin
              raw_left = code_acc[2:0];
              parse_ph = (raw_left != '0) ? PH_RAWBYTE : PH_PREFIX;
            end
            default: begin
              put_text(code_acc);
              raw_left = raw_left - 3'd1;
              if (raw_left == '0)
                parse_ph = PH_PREFIX;
            end
          endcase
          code_acc = '0;
        end
      end
    endcase
  endfunction

  // advance the predictor by one accepted transaction and queue its text bytes
  function automatic void decode_txn(input stim_row_t r);
    text_rec_t rec;
    emit_n   = 0;
    emit_acc = '0;
    case (r.command)
      CMD_LOAD_TK: begin
        token_len[r.index]  = (r.length > TOK_LEN_MAX) ? TOK_LEN_MAX : r.length;
        token_text[r.index] = r.bytes;
      end
      CMD_LOAD_L1: begin
        if (int'(r.index) < L1_DEPTH) begin
          sym1_len[r.index[4:0]]  = (r.length > SYM_LEN_MAX) ? SYM_LEN_MAX : r.length;
          sym1_text[r.index[4:0]] = r.bytes[47:16];
        end
      end
      CMD_LOAD_L2: begin
        sym2_len[r.index]  = (r.length > SYM_LEN_MAX) ? SYM_LEN_MAX : r.length;
        sym2_text[r.index] = r.bytes[47:16];
      end
      CMD_DECODE: begin
        for (int k = 3; k >= 0; k--)
          take_code_bit(r.nibble[k]);
        if (r.last)
          clear_parser();
      end
      default: ;
    endcase
    if (r.typed) begin
      emit_n   = int'(r.exp_count);
      emit_acc = r.exp_bytes;
    end
    for (int k = 0; k < emit_n; k++) begin
      rec.text = emit_acc[47 - 8 * k -: 8];
      rec.last = (k == emit_n - 1);
      text_expected = {text_expected, rec};
    end
  endfunction

  function automatic int draw_wait(inout bit steady);
    if ($urandom_range(0, 24) == 0)
      steady = !steady;
    return steady ? 0 : int'($urandom_range(0, 10));
  endfunction

  function automatic logic [7:0] pick_index();
    if ($urandom_range(0, 3) == 0)
      return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 7));
  endfunction

  function automatic stim_row_t random_row(input logic [1:0] cmd);
    stim_row_t r;
    r           = '0;
    r.command   = cmd;
    r.nibble    = 4'($urandom_range(0, 15));
    r.last      = 1'($urandom_range(0, 1));
    r.index     = pick_index();
    r.length    = 3'($urandom_range(0, 7));
    r.bytes     = {16'($urandom()), 32'($urandom())};
    return r;
  endfunction

  function automatic void push_bits(input logic [7:0] v, input int w);
    for (int j = w - 1; j >= 0; j--)
      code_bits = {code_bits, v[j]};
  endfunction

  task automatic send_txn(input stim_row_t r);
    int gap;
    gap = draw_wait(in_steady);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= r.command;
    in_ch.code_nibble  <= r.nibble;
    in_ch.message_end  <= r.last;
    in_ch.entry_index  <= r.index;
    in_ch.entry_length <= r.length;
    in_ch.entry_bytes  <= r.bytes;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_txn(r);
    if (!(r.command == CMD_LOAD_L1 && int'(r.index) >= L1_DEPTH))
      stim_count++;
  endtask

  task automatic send_random_load();
    send_txn(random_row(2'($urandom_range(1, 3))));
  endtask

  // one message of random codes; sometimes cut short, sometimes left open
  task automatic send_random_message();
    int        codes;
    int        cnt;
    int        nnib;
    bit        closes;
    logic [7:0] idx;
    stim_row_t r;
    code_bits.delete();
    codes = $urandom_range(1, 4);
    for (int i = 0; i < codes; i++) begin
      idx = pick_index();
      case ($urandom_range(0, 3))
        0: begin
          push_bits(8'b0, 1);
          push_bits(idx, 8);
        end
        1: begin
          push_bits(8'b10, 2);
          push_bits(idx, 5);
        end
        2: begin
          push_bits(8'b110, 3);
          push_bits(idx, 8);
        end
        default: begin
          cnt = $urandom_range(0, 7);
          push_bits(8'b111, 3);
          push_bits(8'(cnt), 3);
          for (int j = 0; j < cnt; j++)
            push_bits(8'($urandom_range(0, 255)), 8);
        end
      endcase
    end
    while (code_bits.size() % 4 != 0)
      code_bits = {code_bits, 1'($urandom_range(0, 1))};
    nnib = code_bits.size() / 4;
    if ($urandom_range(0, 5) == 0)
      nnib = $urandom_range(1, nnib);
    closes = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < nnib; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_random_load();
      r        = random_row(CMD_DECODE);
      r.nibble = {code_bits[4 * i], code_bits[4 * i + 1],
                  code_bits[4 * i + 2], code_bits[4 * i + 3]};
      r.last   = closes && (i == nnib - 1);
      send_txn(r);
    end
  endtask

  function automatic void note_fault(input string what, input text_rec_t want,
                                     input text_rec_t got);
    faults++;
    if (faults <= MAX_REPORTS)
      $display("%0t %s: expected %02h last %0b, got %02h last %0b", $realtime, what,
               want.text, want.last, got.text, got.last);
  endfunction

  initial begin
    int target;
    faults     = 0;
    stim_count = 0;
    in_steady  = 1'b0;
    clear_model();
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= CMD_DECODE;
    in_ch.code_nibble  <= '0;
    in_ch.message_end  <= 1'b0;
    in_ch.entry_index  <= '0;
    in_ch.entry_length <= '0;
    in_ch.entry_bytes  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED_ROWS[i])
      send_txn(DIRECTED_ROWS[i]);
    target = stim_count + RANDOM_ITEMS;
    while (stim_count < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_random_load();
        9: begin
          repeat ($urandom_range(1, 3))
            send_txn(random_row(CMD_DECODE));
        end
        default: send_random_message();
      endcase
    end
    in_ch.valid <= 1'b0;
    while (text_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (faults == 0)
      $display("dictionary_prefix_nibble_decoder regression: pass");
    else
      $display("dictionary_prefix_nibble_decoder regression: fail");
    $finish;
  end

  initial begin
    int        w;
    bit        steady;
    text_rec_t got;
    text_rec_t want;
    steady = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      w = draw_wait(steady);
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.text = out_ch.text_byte;
      got.last = out_ch.run_last;
      if (text_expected.size() == 0) begin
        note_fault("unexpected text byte", '0, got);
      end else begin
        want = text_expected.pop_front();
        if (got.text !== want.text || got.last !== want.last)
          note_fault("text byte mismatch", want, got);
      end
    end
  end

  // hold a count of cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("dictionary_prefix_nibble_decoder regression: fail");
      $finish;
    end
  end

  initial idle_cycles = 0;

endmodule

@@ files.f @@
rtl/dpnd_pkg.sv
rtl/dpnd_if.sv
rtl/dpnd_ram.sv
rtl/dpnd_parser.sv
rtl/dpnd_emit.sv
rtl/dictionary_prefix_nibble_decoder.sv
tb/tb.sv
